// ----- src/gbts_pkg.sv -----
// Shared types and constants for the gap buffer text store.
// Used by gbts_ctrl, gbts_dp and gap_buffer_text_store_top; depends on nothing.
package gbts_pkg;

	localparam int POS_W = 11;

	// Operation codes carried in the opcode field.
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_MOVE   = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_DELSEL = 3'd4;

	// Status codes reported with every result.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [7:0]       data_byte;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] position_end;
	} req_item_t;

	typedef struct packed {
		logic [7:0]       read_byte;
		logic [1:0]       status;
		logic [POS_W-1:0] text_length;
		logic [POS_W-1:0] cursor;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_MOVE,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic finish;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] opcode;
		logic       at_target;
		logic       out_free;
	} ctrl_sts_t;

endpackage

// ----- src/gbts_ctrl.sv -----
// Controller state machine for the gap buffer text store.
// Depends on gbts_pkg; drives the datapath through ctrl_cmd_t.
module gbts_ctrl
	import gbts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.opcode)
					OP_MOVE, OP_DELSEL: state_nxt = ST_MOVE;
					OP_READ:            state_nxt = ST_READ;
					default:            state_nxt = ST_DONE;
				endcase
			end
			ST_READ: begin
				state_nxt = ST_DONE;
			end
			ST_MOVE: begin
				if (sts.at_target) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/gbts_dp.sv -----
// Datapath of the gap buffer text store: text memory, gap pointers and result register.
// Depends on gbts_pkg; sequenced by gbts_ctrl.
module gbts_dp
	import gbts_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = (PW > POS_W) ? PW : POS_W;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	logic [7:0]    mem [CAPACITY];
	logic [7:0]    rd_data_q;

	req_item_t     cmd_q;
	logic [PW-1:0] gap_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] target_q;
	logic [PW-1:0] del_q;
	logic [1:0]    status_q;
	logic          rd_ok_q;
	logic          wr_valid_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          rsp_valid_q;
	rsp_item_t     rsp_q;

	logic [PW-1:0] len;
	logic [EW-1:0] len_e;
	logic [EW-1:0] pos_e;
	logic [EW-1:0] pend_e;
	logic [EW-1:0] lo_e;
	logic [EW-1:0] hi_e;
	logic [EW-1:0] hi_c;
	logic [EW-1:0] lo_c;
	logic [EW-1:0] del_e;
	logic [PW-1:0] move_tgt;
	logic          full;
	logic          rd_oor;
	logic [PW-1:0] rd_idx;
	logic          move_left;
	logic          ins_we;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [PW-1:0] gap_m1;
	logic [PW-1:0] tail_m1;

	// Text length, operand clamping and read address.
	always_comb begin
		len    = gap_q + (CAP_P - tail_q);
		len_e  = EW'(len);
		pos_e  = EW'(cmd_q.position);
		pend_e = EW'(cmd_q.position_end);
		full   = (gap_q == tail_q);
		rd_oor = (pos_e >= len_e);
		if (pos_e < EW'(gap_q)) begin
			rd_idx = pos_e[PW-1:0];
		end else begin
			rd_idx = pos_e[PW-1:0] + (tail_q - gap_q);
		end
		move_tgt = (pos_e > len_e) ? len : pos_e[PW-1:0];
		if (pos_e > pend_e) begin
			lo_e = pend_e;
			hi_e = pos_e;
		end else begin
			lo_e = pos_e;
			hi_e = pend_e;
		end
		hi_c      = (hi_e > len_e) ? len_e : hi_e;
		lo_c      = (lo_e > hi_c) ? hi_c : lo_e;
		del_e     = hi_c - lo_c;
		move_left = (gap_q > target_q);
		gap_m1    = gap_q - PW'(1);
		tail_m1   = tail_q - PW'(1);
	end

	// Memory port selection: insert write, move copy write, read op, move read.
	always_comb begin
		ins_we    = cmd.exec && (cmd_q.opcode == OP_INSERT) && !full;
		mem_we    = ins_we || wr_valid_s1;
		mem_waddr = wr_valid_s1 ? wr_addr_s1 : gap_q[AW-1:0];
		mem_wdata = wr_valid_s1 ? rd_data_q : cmd_q.data_byte;
		mem_re    = 1'b0;
		mem_raddr = rd_idx[AW-1:0];
		if (cmd.exec && (cmd_q.opcode == OP_READ) && !rd_oor) begin
			mem_re = 1'b1;
		end else if (cmd.step) begin
			mem_re    = 1'b1;
			mem_raddr = move_left ? gap_m1[AW-1:0] : tail_q[AW-1:0];
		end
	end

	// Text memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Transaction fields and per-operation operands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req;
		end
		if (cmd.exec) begin
			target_q <= (cmd_q.opcode == OP_DELSEL) ? hi_c[PW-1:0] : move_tgt;
			del_q    <= (cmd_q.opcode == OP_DELSEL) ? del_e[PW-1:0] : '0;
			rd_ok_q  <= (cmd_q.opcode == OP_READ) && !rd_oor;
			if ((cmd_q.opcode == OP_INSERT) && full) begin
				status_q <= STS_FULL;
			end else if ((cmd_q.opcode == OP_READ) && rd_oor) begin
				status_q <= STS_RANGE;
			end else begin
				status_q <= STS_OK;
			end
		end
		if (cmd.step) begin
			wr_addr_s1 <= move_left ? tail_m1[AW-1:0] : gap_q[AW-1:0];
		end
	end

	// Gap pointers and the pending copy write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= '0;
			tail_q      <= CAP_P;
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= cmd.step;
			if (ins_we) begin
				gap_q <= gap_q + PW'(1);
			end else if (cmd.exec && (cmd_q.opcode == OP_DELETE) && (gap_q != '0)) begin
				gap_q <= gap_m1;
			end else if (cmd.step) begin
				if (move_left) begin
					gap_q  <= gap_m1;
					tail_q <= tail_m1;
				end else begin
					gap_q  <= gap_q + PW'(1);
					tail_q <= tail_q + PW'(1);
				end
			end else if (cmd.finish) begin
				gap_q <= gap_q - del_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.read_byte   <= rd_ok_q ? rd_data_q : 8'd0;
			rsp_q.status      <= status_q;
			rsp_q.text_length <= len_e[POS_W-1:0];
			rsp_q.cursor      <= POS_W'(gap_q);
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;
	assign sts.opcode    = cmd_q.opcode;
	assign sts.at_target = (gap_q == target_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// The gap never closes past itself and the tail never leaves the store.
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q <= tail_q)
		else $error("gap start passed tail start");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CAP_P)
		else $error("tail start beyond capacity");

	// A copy write and an insert write never compete for the write port.
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_valid_s1 && ins_we))
		else $error("copy write collides with insert");

	// A move step is issued only while the cursor is short of its target.
	a_step_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (gap_q != target_q))
		else $error("move step at target");

	// Every copy read is followed by its write in the next cycle.
	a_copy_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> mem_we && wr_valid_s1)
		else $error("copy write missing after move read");

endmodule

// ----- src/gap_buffer_text_store_top.sv -----
// Gap buffer text store, top level: joins the controller and the datapath.
// Depends on gbts_pkg, gbts_ctrl and gbts_dp.
//
// Usage: each request transaction on the req channel (req_valid, req_stall, req)
// is one editing operation: insert, delete before cursor, move cursor, read at
// index or delete selection. Each produces exactly one response transaction on
// the rsp channel (rsp_valid, rsp_stall, rsp) with the read byte, a status, the
// text length and the cursor after the operation.
// Requests are taken one at a time. Insert, delete and unused opcodes pass from
// the execute state to the done state; a read adds a read state, as the text
// memory has a registered read port. Cursor moves and selection deletes add a
// move state that copies the bytes across the gap, at most CAPACITY of them;
// the single memory port pair carries one byte per cycle. The next request is
// accepted the cycle after the result is loaded, even while that result is
// still stalled in the response register.
// While rsp_stall holds a result, a finished second operation waits in the
// controller and req_stall stays high. Reset empties the text and puts the
// cursor at zero; memory contents are not cleared and are never read unwritten.
module gap_buffer_text_store_top
	import gbts_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// Operation sequencer.
	gbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Text memory, pointers and response register.
	gbts_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- verif/gap_buffer_text_store_top_tb.sv -----
// Self-checking testbench for gap_buffer_text_store_top: a directed table, then random
// edit transactions, each result checked against its typed table row or a predictor of the text store.
// Depends on gbts_pkg and gap_buffer_text_store_top.
module gap_buffer_text_store_top_tb;
	import gbts_pkg::*;

	localparam int CAP = 1024;
	localparam int unsigned LIMIT = 8_000_000;
	localparam int unsigned ITEMS = 1250;

	// Opcodes the block treats as no-ops.
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	gap_buffer_text_store_top #(.CAPACITY(CAP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Predicted text store: bytes before the cursor sit below gap_pos, the rest from tail_pos up.
	logic [7:0]  text_mem [0:CAP-1];
	int unsigned gap_pos;
	int unsigned tail_pos;

	rsp_item_t   due_results [$];
	bit          idle_on;
	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned full_refusals;
	int unsigned range_reads;
	int unsigned cycles;
	int unsigned stall_left;

	function automatic int unsigned text_len();
		return gap_pos + CAP - tail_pos;
	endfunction

	// Copy bytes across the gap one at a time until the cursor reaches the clamped target.
	function automatic void shift_gap(input int unsigned target);
		int unsigned len;
		len = text_len();
		if (target > len)
			target = len;
		while (gap_pos > target && tail_pos > 0) begin
			gap_pos--;
			tail_pos--;
			text_mem[tail_pos] = text_mem[gap_pos];
		end
		while (gap_pos < target && tail_pos < CAP) begin
			text_mem[gap_pos] = text_mem[tail_pos];
			gap_pos++;
			tail_pos++;
		end
	endfunction

	// Apply one edit to the predicted store and return the result it should produce.
	function automatic rsp_item_t edit_text(input req_item_t r);
		rsp_item_t   res;
		int unsigned lo;
		int unsigned hi;
		int unsigned idx;
		int unsigned len;
		res = '0;
		res.status = STS_OK;
		case (r.opcode)
			OP_INSERT: begin
				if (gap_pos >= tail_pos) begin
					res.status = STS_FULL;
				end else begin
					text_mem[gap_pos] = r.data_byte;
					gap_pos++;
				end
			end
			OP_DELETE: begin
				if (gap_pos > 0)
					gap_pos--;
			end
			OP_MOVE: begin
				shift_gap(r.position);
			end
			OP_READ: begin
				len = text_len();
				if (r.position >= len) begin
					res.status = STS_RANGE;
				end else if (r.position < gap_pos) begin
					res.read_byte = text_mem[r.position];
				end else begin
					idx = r.position + tail_pos - gap_pos;
					if (idx < CAP)
						res.read_byte = text_mem[idx];
				end
			end
			OP_DELSEL: begin
				lo = r.position;
				hi = r.position_end;
				if (lo > hi) begin
					lo = r.position_end;
					hi = r.position;
				end
				len = text_len();
				if (hi > len)
					hi = len;
				if (lo > hi)
					lo = hi;
				shift_gap(hi);
				gap_pos -= hi - lo;
			end
			default: begin
			end
		endcase
		res.text_length = POS_W'(text_len());
		res.cursor = POS_W'(gap_pos);
		return res;
	endfunction

	// A position mostly close to the cursor, sometimes at or past the text end or anywhere.
	function automatic logic [POS_W-1:0] aim_pos(input int unsigned len);
		int unsigned lo;
		int unsigned hi;
		lo = (gap_pos > 32) ? gap_pos - 32 : 0;
		hi = (gap_pos + 32 > len) ? len : gap_pos + 32;
		case ($urandom_range(0, 9))
			0: return POS_W'($urandom);
			1: return POS_W'(len);
			2: return POS_W'(len + $urandom_range(1, 8));
			default: return POS_W'($urandom_range(lo, hi));
		endcase
	endfunction

	// Random edit shaped by the predicted state; ins_w is the insert share in percent.
	function automatic req_item_t pick_op(input int unsigned ins_w);
		req_item_t   r;
		int unsigned len;
		int unsigned roll;
		len = text_len();
		r.opcode = OP_INSERT;
		r.data_byte = 8'($urandom);
		r.position = POS_W'($urandom);
		r.position_end = POS_W'($urandom);
		if ($urandom_range(0, 99) >= ins_w) begin
			roll = $urandom_range(0, 19);
			if (roll < 4) begin
				r.opcode = OP_DELETE;
			end else if (roll < 9) begin
				r.opcode = OP_MOVE;
				r.position = aim_pos(len);
			end else if (roll < 15) begin
				r.opcode = OP_READ;
				if (len > 0 && $urandom_range(0, 4) != 0)
					r.position = POS_W'($urandom_range(0, len - 1));
				else
					r.position = aim_pos(len);
			end else if (roll < 18) begin
				r.opcode = OP_DELSEL;
				r.position = aim_pos(len);
				if ($urandom_range(0, 4) != 0)
					r.position_end = POS_W'(r.position + $urandom_range(0, 16));
				if ($urandom_range(0, 1) == 0)
					{r.position, r.position_end} = {r.position_end, r.position};
			end else if (roll < 19) begin
				r.opcode = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
			end
		end
		return r;
	endfunction

	// Offer one request transaction, wait for it to be taken, and log what it should return.
	task automatic send_op(input req_item_t r, input bit typed, input rsp_item_t want);
		int unsigned idle;
		rsp_item_t   got;
		idle = idle_on ? $urandom_range(0, 3) : 0;
		if (idle != 0) begin
			req_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		got = edit_text(r);
		if (got.status == STS_FULL)
			full_refusals++;
		if (got.status == STS_RANGE)
			range_reads++;
		due_results.push_back(typed ? want : got);
		items_sent++;
	endtask

	// Hold off new requests until every pending result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// Directed table; rows with typed set carry a result that is plain from the text contents.
	typedef struct packed {
		req_item_t op;
		logic      typed;
		rsp_item_t want;
	} dir_row_t;

	dir_row_t dir_tab [0:25] = '{
		'{'{OP_DELETE, 8'h00, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd0, 11'd0}},
		'{'{OP_READ, 8'h00, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_RANGE, 11'd0, 11'd0}},
		'{'{OP_READ, 8'hFF, 11'd2047, 11'd2047}, 1'b1, '{8'h00, STS_RANGE, 11'd0, 11'd0}},
		'{'{OP_INSERT, 8'hFF, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd1, 11'd1}},
		'{'{OP_INSERT, 8'h00, 11'd2047, 11'd2047}, 1'b1, '{8'h00, STS_OK, 11'd2, 11'd2}},
		'{'{OP_INSERT, 8'h5A, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd3, 11'd3}},
		'{'{OP_MOVE, 8'h00, 11'd2047, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd3, 11'd3}},
		'{'{OP_MOVE, 8'h00, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd3, 11'd0}},
		'{'{OP_READ, 8'h00, 11'd0, 11'd0}, 1'b1, '{8'hFF, STS_OK, 11'd3, 11'd0}},
		'{'{OP_READ, 8'h00, 11'd1, 11'd0}, 1'b1, '{8'h00, STS_OK, 11'd3, 11'd0}},
		'{'{OP_READ, 8'h00, 11'd2, 11'd0}, 1'b0, '0},
		'{'{OP_READ, 8'h00, 11'd3, 11'd0}, 1'b1, '{8'h00, STS_RANGE, 11'd3, 11'd0}},
		'{'{OP_INSERT, 8'h80, 11'd0, 11'd0}, 1'b0, '0},
		'{'{OP_MOVE, 8'h00, 11'd2, 11'd0}, 1'b0, '0},
		'{'{OP_DELETE, 8'h00, 11'd0, 11'd0}, 1'b0, '0},
		'{'{OP_SPARE_5, 8'hFF, 11'd2047, 11'd2047}, 1'b0, '0},
		'{'{OP_SPARE_6, 8'h00, 11'd1024, 11'd0}, 1'b0, '0},
		'{'{OP_SPARE_7, 8'hA5, 11'd0, 11'd1024}, 1'b0, '0},
		'{'{OP_INSERT, 8'h11, 11'd0, 11'd0}, 1'b0, '0},
		'{'{OP_DELSEL, 8'h00, 11'd2047, 11'd1}, 1'b0, '0},
		'{'{OP_DELSEL, 8'h00, 11'd1, 11'd1}, 1'b0, '0},
		'{'{OP_INSERT, 8'h22, 11'd0, 11'd0}, 1'b0, '0},
		'{'{OP_INSERT, 8'h33, 11'd0, 11'd0}, 1'b0, '0},
		'{'{OP_DELSEL, 8'h00, 11'd3, 11'd0}, 1'b0, '0},
		'{'{OP_DELSEL, 8'h00, 11'd0, 11'd2047}, 1'b1, '{8'h00, STS_OK, 11'd0, 11'd0}},
		'{'{OP_READ, 8'h00, 11'd0, 11'd0}, 1'b1, '{8'h00, STS_RANGE, 11'd0, 11'd0}}
	};

	// Response side: after each taken result, stall the channel at random while idling is on.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			stall_left = idle_on ? $urandom_range(0, 3) : 0;
			rsp_stall <= (stall_left != 0);
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= (stall_left != 0);
		end
	end

	// Compare each taken response transaction with the oldest pending prediction.
	always @(posedge clk) begin : check_results
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: no request outstanding");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				results_seen++;
				if (rsp.read_byte !== want.read_byte) begin
					$error("read_byte: expected %0d, actual %0d", want.read_byte, rsp.read_byte);
					fail_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.text_length !== want.text_length) begin
					$error("text_length: expected %0d, actual %0d",
						want.text_length, rsp.text_length);
					fail_count++;
				end
				if (rsp.cursor !== want.cursor) begin
					$error("cursor: expected %0d, actual %0d", want.cursor, rsp.cursor);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("gap_buffer_text_store_top: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		req_item_t   r;
		int unsigned fill_guard;
		int unsigned mixed_end;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		stall_left = 0;
		idle_on = 1'b1;
		fail_count = 0;
		items_sent = 0;
		results_seen = 0;
		full_refusals = 0;
		range_reads = 0;
		cycles = 0;
		gap_pos = 0;
		tail_pos = CAP;
		foreach (text_mem[i])
			text_mem[i] = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edge cases.
		foreach (dir_tab[i])
			send_op(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
		drain();

		// Mixed edits on a short text, with stretches of idling switched on and off.
		while (items_sent < 120) begin
			if (items_sent % 50 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) == 0)
				drain();
			send_op(pick_op(45), 1'b0, '0);
		end
		drain();

		// Grow the text until the store is full, then push on a full buffer.
		fill_guard = 0;
		while (text_len() < CAP && fill_guard < 3000) begin
			if (fill_guard % 64 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_op(pick_op(96), 1'b0, '0);
			fill_guard++;
		end
		idle_on = 1'b1;
		repeat (4) begin
			r = pick_op(100);
			send_op(r, 1'b0, '0);
		end
		r = '{OP_READ, 8'h00, POS_W'(CAP - 1), 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_READ, 8'h00, POS_W'(CAP), 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_MOVE, 8'h00, 11'd0, 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_INSERT, 8'hC3, 11'd0, 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_MOVE, 8'h00, 11'd2047, 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_DELETE, 8'h00, 11'd0, 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_INSERT, 8'h3C, 11'd0, 11'd0};
		send_op(r, 1'b0, '0);
		r = '{OP_INSERT, 8'h7E, 11'd0, 11'd0};
		send_op(r, 1'b0, '0);
		drain();

		// Delete-heavy mix that shrinks the text again.
		mixed_end = (items_sent + 50 > ITEMS) ? items_sent + 50 : ITEMS;
		while (items_sent < mixed_end) begin
			if (items_sent % 50 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) == 0)
				drain();
			send_op(pick_op(20), 1'b0, '0);
		end

		drain();
		repeat (40) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fail_count++;
		end
		$display("Ran %0d edit transactions and checked %0d results, filling the store once.",
			items_sent, results_seen);
		$display("Saw %0d inserts refused on a full store and %0d reads out of range.",
			full_refusals, range_reads);
		if (fail_count == 0)
			$display("gap_buffer_text_store_top: match");
		else
			$display("gap_buffer_text_store_top: mismatch");
		$finish;
	end

endmodule
